// ----- design/pixel_pearson_correlation_top_assert.svh -----
// assertion macros shared by the pearson correlation checker
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef PIXEL_PEARSON_CORRELATION_TOP_ASSERT_SVH
`define PIXEL_PEARSON_CORRELATION_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PPC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the following cycle
`define PPC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/ppc_pkg.sv -----
// shared types and constants for the pearson correlation block
// no dependencies
package ppc_pkg;

   localparam int DEF_MAX_PIXELS_LOG2 = 24;
   localparam int Q_W = 15;
   localparam logic [Q_W-1:0] Q_ONE = 15'd16384;
   localparam int ODD_W = 30;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NUM1,
      ST_NUM2,
      ST_VA1,
      ST_VA2,
      ST_VB1,
      ST_VB2,
      ST_CHECK,
      ST_LHS,
      ST_RHS,
      ST_SEARCH,
      ST_EMIT
   } st_type;

   typedef struct packed {
      logic add;
      logic clear;
   } acc_ctl_type;

endpackage

// ----- design/pixel_pearson_correlation_top.sv -----
// pearson correlation of two luma windows: accumulator, shared multiplier, sequencer
// depends on ppc_pkg, ppc_accum, ppc_mul
//
// usage: drive req_pixel_a/req_pixel_b/req_last with start high; the item is
// taken when busy is low. a pair with req_last low is added to the sums and
// busy stays low, so pairs may stream one per cycle. a pair with req_last high
// raises busy while the sequencer runs every product through one shift-add
// multiplier that retires one multiplier bit per cycle:
//   six sum products with multipliers of at most P+16 bits, then num^2 and
//   va*vb with 2*P+16 bit multipliers, then a binary search of at most 15
//   steps, each step a 30 bit multiply.
// the result then shows on rsp_correlation/rsp_flat for one cycle with
// rsp_strobe high; the receiver cannot stall, the item is taken that cycle.
// the sums clear in that same cycle and busy falls after it.
// pairs beyond 2^MAX_PIXELS_LOG2 in a window are dropped from the sums.
// reset clears the sums and returns the sequencer to idle.
module pixel_pearson_correlation_top import ppc_pkg::*; #(
   parameter int MAX_PIXELS_LOG2 = DEF_MAX_PIXELS_LOG2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [7:0]         req_pixel_a,
   input  logic [7:0]         req_pixel_b,
   input  logic               req_last,
   output logic               rsp_strobe,
   output logic signed [15:0] rsp_correlation,
   output logic               rsp_flat
);
   localparam int CW = MAX_PIXELS_LOG2 + 1;
   localparam int SW = MAX_PIXELS_LOG2 + 8;
   localparam int QW = MAX_PIXELS_LOG2 + 16;
   localparam int VW = 2 * MAX_PIXELS_LOG2 + 16;
   localparam int LW = 2 * VW;
   localparam int WW = LW + ODD_W;
   localparam int BW = (VW > ODD_W) ? VW : ODD_W;

   st_type        st_ff, st_in;
   acc_ctl_type   acc_ctl;
   logic [CW-1:0] pair_count;
   logic [SW-1:0] sum_a, sum_b;
   logic [QW-1:0] sum_a_sq, sum_b_sq, sum_ab;

   logic          mul_start, mul_done;
   logic [WW-1:0] op_a, product;
   logic [BW-1:0] op_b;

   logic          issued_ff, issued_in;
   logic [VW-1:0] t1_ff, t1_in, num_ff, num_in, va_ff, va_in, vb_ff, vb_in;
   logic [LW-1:0] lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic          neg_ff, neg_in, flat_ff, flat_in;
   logic [Q_W-1:0] lo_ff, lo_in, hi_ff, hi_in, mid, odd;
   logic [Q_W:0]   mid_sum;
   logic [ODD_W-1:0] odd_sq;
   logic [VW-1:0] prod_v, diff;
   logic          accept;

   assign accept = start && (st_ff == ST_IDLE);

   ppc_accum #(.MAX_PIXELS_LOG2(MAX_PIXELS_LOG2)) u_accum (
      .clock(clock), .reset(reset), .ctl(acc_ctl),
      .pixel_a(req_pixel_a), .pixel_b(req_pixel_b),
      .pair_count(pair_count), .sum_a(sum_a), .sum_b(sum_b),
      .sum_a_sq(sum_a_sq), .sum_b_sq(sum_b_sq), .sum_ab(sum_ab)
   );

   ppc_mul #(.AW(WW), .BW(BW)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .op_a(op_a), .op_b(op_b), .done(mul_done), .product(product)
   );

   assign prod_v  = product[VW-1:0];
   assign diff    = (t1_ff >= prod_v) ? (t1_ff - prod_v) : (prod_v - t1_ff);
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} + (Q_W+1)'(1);
   assign mid     = mid_sum[Q_W:1];
   assign odd     = {mid[Q_W-2:0], 1'b0} - Q_W'(1);
   assign odd_sq  = ODD_W'(odd) * ODD_W'(odd);

   always_comb begin
      st_in       = st_ff;
      issued_in   = issued_ff;
      t1_in       = t1_ff;
      num_in      = num_ff;
      va_in       = va_ff;
      vb_in       = vb_ff;
      lhs_in      = lhs_ff;
      rhs_in      = rhs_ff;
      neg_in      = neg_ff;
      flat_in     = flat_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mul_start   = 1'b0;
      op_a        = '0;
      op_b        = '0;
      acc_ctl.add   = accept;
      acc_ctl.clear = 1'b0;
      rsp_strobe  = 1'b0;

      case (st_ff)
         ST_NUM1, ST_VA1, ST_VB1: begin
            op_a = WW'(pair_count);
            op_b = (st_ff == ST_NUM1) ? BW'(sum_ab) :
                   (st_ff == ST_VA1)  ? BW'(sum_a_sq) : BW'(sum_b_sq);
         end
         ST_NUM2: begin op_a = WW'(sum_a); op_b = BW'(sum_b); end
         ST_VA2:  begin op_a = WW'(sum_a); op_b = BW'(sum_a); end
         ST_VB2:  begin op_a = WW'(sum_b); op_b = BW'(sum_b); end
         ST_LHS:  begin op_a = WW'(num_ff); op_b = BW'(num_ff); end
         ST_RHS:  begin op_a = WW'(va_ff); op_b = BW'(vb_ff); end
         ST_SEARCH: begin op_a = WW'(rhs_ff); op_b = BW'(odd_sq); end
         default: begin op_a = '0; op_b = '0; end
      endcase

      case (st_ff)
         ST_IDLE: begin
            issued_in = 1'b0;
            if (accept && req_last) st_in = ST_NUM1;
         end
         ST_NUM1, ST_NUM2, ST_VA1, ST_VA2, ST_VB1, ST_VB2, ST_LHS, ST_RHS: begin
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (mul_done) begin
               issued_in = 1'b0;
               case (st_ff)
                  ST_NUM1: begin t1_in = prod_v; st_in = ST_NUM2; end
                  ST_NUM2: begin
                     num_in = diff;
                     neg_in = t1_ff < prod_v;
                     st_in  = ST_VA1;
                  end
                  ST_VA1: begin t1_in = prod_v; st_in = ST_VA2; end
                  ST_VA2: begin va_in = diff; st_in = ST_VB1; end
                  ST_VB1: begin t1_in = prod_v; st_in = ST_VB2; end
                  ST_VB2: begin vb_in = diff; st_in = ST_CHECK; end
                  ST_LHS: begin lhs_in = product[LW-1:0]; st_in = ST_RHS; end
                  default: begin
                     rhs_in = product[LW-1:0];
                     lo_in  = '0;
                     hi_in  = Q_ONE;
                     st_in  = ST_SEARCH;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            flat_in = (va_ff == '0) || (vb_ff == '0);
            lo_in   = '0;
            st_in   = flat_in ? ST_EMIT : ST_LHS;
         end
         ST_SEARCH: begin
            if (lo_ff >= hi_ff) begin
               st_in = ST_EMIT;
            end else if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (mul_done) begin
               issued_in = 1'b0;
               // largest k with 2^30 num^2 >= (2k-1)^2 va vb
               if ({lhs_ff, {ODD_W{1'b0}}} >= product) lo_in = mid;
               else hi_in = mid - Q_W'(1);
            end
         end
         ST_EMIT: begin
            rsp_strobe    = 1'b1;
            acc_ctl.clear = 1'b1;
            flat_in       = 1'b0;
            st_in         = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         issued_ff <= 1'b0;
         flat_ff   <= 1'b0;
      end else begin
         st_ff     <= st_in;
         issued_ff <= issued_in;
         flat_ff   <= flat_in;
      end
      t1_ff  <= t1_in;
      num_ff <= num_in;
      va_ff  <= va_in;
      vb_ff  <= vb_in;
      lhs_ff <= lhs_in;
      rhs_ff <= rhs_in;
      neg_ff <= neg_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
   end

   assign busy            = (st_ff != ST_IDLE);
   assign rsp_flat        = flat_ff;
   assign rsp_correlation = neg_ff ? (16'sd0 - signed'({1'b0, lo_ff}))
                                   : signed'({1'b0, lo_ff});
endmodule

// ----- design/ppc_accum.sv -----
// pixel count and running sums of a, b, a*a, b*b, a*b
// depends on ppc_pkg
module ppc_accum import ppc_pkg::*; #(
   parameter int MAX_PIXELS_LOG2 = DEF_MAX_PIXELS_LOG2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  acc_ctl_type                  ctl,
   input  logic [7:0]                   pixel_a,
   input  logic [7:0]                   pixel_b,
   output logic [MAX_PIXELS_LOG2:0]     pair_count,
   output logic [MAX_PIXELS_LOG2+7:0]   sum_a,
   output logic [MAX_PIXELS_LOG2+7:0]   sum_b,
   output logic [MAX_PIXELS_LOG2+15:0]  sum_a_sq,
   output logic [MAX_PIXELS_LOG2+15:0]  sum_b_sq,
   output logic [MAX_PIXELS_LOG2+15:0]  sum_ab
);
   localparam int CW = MAX_PIXELS_LOG2 + 1;
   localparam int SW = MAX_PIXELS_LOG2 + 8;
   localparam int QW = MAX_PIXELS_LOG2 + 16;

   logic [CW-1:0] count_ff;
   logic [SW-1:0] sa_ff, sb_ff;
   logic [QW-1:0] saa_ff, sbb_ff, sab_ff;
   logic          room;

   // count saturates at the window limit, later pairs are dropped
   assign room = ~count_ff[CW-1];

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         count_ff <= '0;
         sa_ff    <= '0;
         sb_ff    <= '0;
         saa_ff   <= '0;
         sbb_ff   <= '0;
         sab_ff   <= '0;
      end else if (ctl.add && room) begin
         count_ff <= count_ff + CW'(1);
         sa_ff    <= sa_ff + SW'(pixel_a);
         sb_ff    <= sb_ff + SW'(pixel_b);
         saa_ff   <= saa_ff + QW'(16'(pixel_a) * 16'(pixel_a));
         sbb_ff   <= sbb_ff + QW'(16'(pixel_b) * 16'(pixel_b));
         sab_ff   <= sab_ff + QW'(16'(pixel_a) * 16'(pixel_b));
      end
   end

   assign pair_count = count_ff;
   assign sum_a      = sa_ff;
   assign sum_b      = sb_ff;
   assign sum_a_sq   = saa_ff;
   assign sum_b_sq   = sbb_ff;
   assign sum_ab     = sab_ff;
endmodule

// ----- design/ppc_mul.sv -----
// shift-add multiplier, one multiplier bit per cycle, stops when the rest is zero
// depends on ppc_pkg
module ppc_mul import ppc_pkg::*; #(
   parameter int AW = 64,
   parameter int BW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [AW-1:0] op_a,
   input  logic [BW-1:0] op_b,
   output logic          done,
   output logic [AW-1:0] product
);
   logic [AW-1:0] a_ff, a_in, acc_ff, acc_in;
   logic [BW-1:0] b_ff, b_in;
   logic          busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         acc_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (b_ff[0]) acc_in = acc_ff + a_ff;
            a_in = {a_ff[AW-2:0], 1'b0};
            b_in = {1'b0, b_ff[BW-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

// ----- design/ppc_checker.sv -----
// port-level checks for the pearson correlation block, bound to the top level
// depends on pixel_pearson_correlation_top_assert.svh
`include "pixel_pearson_correlation_top_assert.svh"

module ppc_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               req_last,
   input logic               rsp_strobe,
   input logic signed [15:0] rsp_correlation,
   input logic               rsp_flat
);
   `PPC_ASSERT_SAME(a_strobe_busy, rsp_strobe, busy, "result outside a computation")
   `PPC_ASSERT_NEXT(a_strobe_idle, rsp_strobe, !busy, "busy held after result")
   `PPC_ASSERT_NEXT(a_plain_idle, start && !busy && !req_last, !busy, "plain pair raised busy")
   `PPC_ASSERT_NEXT(a_last_busy, start && !busy && req_last, busy, "last pair did not start")
   `PPC_ASSERT_SAME(a_flat_zero, rsp_strobe && rsp_flat, rsp_correlation == 16'sd0, "flat not zero")
endmodule

bind pixel_pearson_correlation_top ppc_checker u_ppc_checker (.*);

// ----- tb/tb_pixel_pearson_correlation_top.sv -----
// self-checking testbench for pixel_pearson_correlation_top: directed windows, then random ones
// depends on ppc_pkg, rtl; expected coefficients: exact wide-integer predictor or a typed row
module tb_pixel_pearson_correlation_top;
   import ppc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIX_LOG2   = DEF_MAX_PIXELS_LOG2;
   localparam int IDLE_LIMIT = 20000;
   localparam int N_RANDOM   = 1550;

   typedef struct packed {
      logic signed [15:0] corr;
      logic               flat;
   } coeff_type;

   typedef struct packed {
      logic [7:0]         a;
      logic [7:0]         b;
      logic               last;
      logic               typed;
      logic signed [15:0] corr;
      logic               flat;
   } pair_row_type;

   logic clock, reset, start, busy;
   logic [7:0] req_pixel_a, req_pixel_b;
   logic req_last;
   logic rsp_strobe, rsp_flat;
   logic signed [15:0] rsp_correlation;

   // window sums kept beside the block
   logic [24:0] pair_cnt;
   logic [31:0] acc_a, acc_b;
   logic [39:0] acc_aa, acc_bb, acc_ab;

   coeff_type pending_coeffs[$];
   int mismatches = 0;
   int windows = 0;
   int flat_windows = 0;
   int items = 0;
   int idle_cycles = 0;

   pair_row_type pair_rows[21] = '{
      '{8'd0,   8'd0,   1'b1, 1'b1, 16'sd0,      1'b1},  // single pair
      '{8'd255, 8'd255, 1'b1, 1'b1, 16'sd0,      1'b1},
      '{8'd0,   8'd0,   1'b0, 1'b0, 16'sd0,      1'b0},  // perfect positive
      '{8'd255, 8'd255, 1'b1, 1'b1, 16'sd16384,  1'b0},
      '{8'd0,   8'd255, 1'b0, 1'b0, 16'sd0,      1'b0},  // perfect negative
      '{8'd255, 8'd0,   1'b1, 1'b1, -16'sd16384, 1'b0},
      '{8'd0,   8'd0,   1'b0, 1'b0, 16'sd0,      1'b0},  // zero covariance
      '{8'd255, 8'd0,   1'b0, 1'b0, 16'sd0,      1'b0},
      '{8'd0,   8'd255, 1'b0, 1'b0, 16'sd0,      1'b0},
      '{8'd255, 8'd255, 1'b1, 1'b1, 16'sd0,      1'b0},
      '{8'd17,  8'd0,   1'b0, 1'b0, 16'sd0,      1'b0},  // flat a
      '{8'd17,  8'd200, 1'b0, 1'b0, 16'sd0,      1'b0},
      '{8'd17,  8'd255, 1'b1, 1'b1, 16'sd0,      1'b1},
      '{8'd3,   8'd9,   1'b0, 1'b0, 16'sd0,      1'b0},  // flat b
      '{8'd200, 8'd9,   1'b1, 1'b1, 16'sd0,      1'b1},
      '{8'd10,  8'd20,  1'b0, 1'b0, 16'sd0,      1'b0},
      '{8'd30,  8'd25,  1'b0, 1'b0, 16'sd0,      1'b0},
      '{8'd200, 8'd90,  1'b0, 1'b0, 16'sd0,      1'b0},
      '{8'd255, 8'd1,   1'b1, 1'b0, 16'sd0,      1'b0},
      '{8'd170, 8'd85,  1'b0, 1'b0, 16'sd0,      1'b0},
      '{8'd85,  8'd170, 1'b1, 1'b0, 16'sd0,      1'b0}
   };

   pixel_pearson_correlation_top i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pixel_a(req_pixel_a), .req_pixel_b(req_pixel_b), .req_last(req_last),
      .rsp_strobe(rsp_strobe), .rsp_correlation(rsp_correlation), .rsp_flat(rsp_flat)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic coeff_type window_coefficient();
      logic [255:0] n, t1, t2, num, va, vb, lhs, prod, rhs, odd;
      logic neg;
      int lo, hi, mid;
      coeff_type r;
      n = 256'(pair_cnt);
      t1 = 256'(acc_ab) * n;
      t2 = 256'(acc_a) * 256'(acc_b);
      neg = t1 < t2;
      num = neg ? t2 - t1 : t1 - t2;
      t1 = 256'(acc_aa) * n;
      t2 = 256'(acc_a) * 256'(acc_a);
      va = t1 - t2;
      t1 = 256'(acc_bb) * n;
      t2 = 256'(acc_b) * 256'(acc_b);
      vb = t1 - t2;
      r.corr = '0;
      r.flat = 1'b0;
      if (va == '0 || vb == '0) begin
         r.flat = 1'b1;
         return r;
      end
      lhs = (num * num) << 30;
      prod = va * vb;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         odd = 256'(2 * mid - 1);
         rhs = odd * odd * prod;
         if (lhs >= rhs) lo = mid;
         else hi = mid - 1;
      end
      r.corr = neg ? -16'(lo) : 16'(lo);
      return r;
   endfunction

   // fold one accepted item into the sums; returns 1 with a coefficient on last
   function automatic bit fold_pair(input logic [7:0] a, input logic [7:0] b,
                                    input logic last, output coeff_type c);
      if (pair_cnt < (25'd1 << PIX_LOG2)) begin
         pair_cnt += 25'd1;
         acc_a += 32'(a);
         acc_b += 32'(b);
         acc_aa += 40'(16'(a) * 16'(a));
         acc_bb += 40'(16'(b) * 16'(b));
         acc_ab += 40'(16'(a) * 16'(b));
      end
      if (!last) return 1'b0;
      c = window_coefficient();
      pair_cnt = '0; acc_a = '0; acc_b = '0;
      acc_aa = '0; acc_bb = '0; acc_ab = '0;
      return 1'b1;
   endfunction

   task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic last,
                            input bit typed, input coeff_type typed_c);
      coeff_type c;
      req_pixel_a <= a;
      req_pixel_b <= b;
      req_last <= last;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      items++;
      if (fold_pair(a, b, last, c)) begin
         if (typed) c = typed_c;
         pending_coeffs.push_back(c);
         windows++;
         if (c.flat) flat_windows++;
      end
   endtask

   // random gaps between bursts of the sender
   int burst_left = 0;
   task automatic maybe_pause();
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 30);
      if ($urandom_range(0, 2) != 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   function automatic logic [7:0] near(input int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return 8'(v);
   endfunction

   initial begin
      coeff_type tc;
      int len, mode, base, sent_rand;
      logic [7:0] a, b;
      start = 1'b0;
      req_pixel_a = '0;
      req_pixel_b = '0;
      req_last = 1'b0;
      reset = 1'b1;
      pair_cnt = '0; acc_a = '0; acc_b = '0;
      acc_aa = '0; acc_bb = '0; acc_ab = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (pair_rows[i]) begin
         tc.corr = pair_rows[i].corr;
         tc.flat = pair_rows[i].flat;
         send_pair(pair_rows[i].a, pair_rows[i].b, pair_rows[i].last, pair_rows[i].typed, tc);
      end

      sent_rand = 0;
      while (sent_rand < N_RANDOM) begin
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 24);
         mode = $urandom_range(0, 5);
         base = $urandom_range(0, 255);
         for (int k = 0; k < len; k++) begin
            a = 8'($urandom_range(0, 255));
            case (mode)
               0: b = 8'($urandom_range(0, 255));
               1: b = near(a + $urandom_range(0, 20) - 10);
               2: b = near(255 - a + $urandom_range(0, 6) - 3);
               3: b = 8'(base);
               4: begin
                  a = near(base + $urandom_range(0, 2) - 1);
                  b = 8'($urandom_range(0, 255));
               end
               default: b = a;
            endcase
            maybe_pause();
            send_pair(a, b, k == len - 1, 1'b0, tc);
            sent_rand++;
         end
         // let everything drain once midway
         if (sent_rand > N_RANDOM / 2 && sent_rand - len <= N_RANDOM / 2) begin
            start <= 1'b0;
            while (pending_coeffs.size() != 0) @(posedge clock);
         end
      end
      start <= 1'b0;
      while (pending_coeffs.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("covered %0d items in %0d windows, %0d of them flat", items, windows,
               flat_windows);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0 && pending_coeffs.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   always @(posedge clock) begin
      coeff_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("FAILURE");
            $finish;
         end
         if (rsp_strobe) begin
            if (pending_coeffs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result corr=%0d flat=%0b", rsp_correlation, rsp_flat);
            end else begin
               want = pending_coeffs.pop_front();
               if (want.corr !== rsp_correlation || want.flat !== rsp_flat) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected corr=%0d flat=%0b, got corr=%0d flat=%0b",
                              want.corr, want.flat, rsp_correlation, rsp_flat);
               end
            end
         end
      end
   end

endmodule
